FILE: hdl/tlb_lru_fully_associative_assert.svh
// ----------------------------------------------------------------------------
// tlb assertion macros
// shared concurrent assertion forms for the translation buffer
// ----------------------------------------------------------------------------
`ifndef TLB_LRU_FULLY_ASSOCIATIVE_ASSERT_SVH
`define TLB_LRU_FULLY_ASSOCIATIVE_ASSERT_SVH

// same-cycle implication, held off during reset
`define TLBL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlb assertion failed");

// next-cycle implication, held off during reset
`define TLBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlb assertion failed");

`endif

FILE: hdl/tlbl_pkg.sv
// ----------------------------------------------------------------------------
// tlbl_pkg
// shared types and constants of the fully associative tlb
// ----------------------------------------------------------------------------
package tlbl_pkg;

    localparam int TLBL_ENTRIES    = 32;
    localparam int TLBL_PAGE_BITS  = 20;
    localparam int TLBL_FRAME_BITS = 20;
    localparam int TLBL_STAMP_BITS = 32;

    // port field widths
    localparam int F_FUNC_W  = 2;
    localparam int F_PAGE_W  = 20;
    localparam int F_FRAME_W = 20;
    localparam int F_STAMP_W = 32;
    localparam int F_IDX_W   = 5;
    localparam int F_CNT_W   = 6;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 56;

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_FLUSH  = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } t_state;

    // flags carried by the scan wave from cell to cell
    typedef struct packed {
        logic active;
        logic found;
        logic free_found;
        logic min_set;
    } t_wave_ctl;

endpackage

FILE: hdl/tlbl_cell.sv
// ----------------------------------------------------------------------------
// tlbl_cell
// one tlb entry plus one stage of the scan wave
// ----------------------------------------------------------------------------
module tlbl_cell
    import tlbl_pkg::*;
#(
    parameter int ENTRIES    = TLBL_ENTRIES,
    parameter int PAGE_BITS  = TLBL_PAGE_BITS,
    parameter int FRAME_BITS = TLBL_FRAME_BITS,
    parameter int IDX        = 0
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic [PAGE_BITS-1:0]                         i_page,
    input  logic                                         i_wr_en,
    input  logic                                         i_inv_en,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_upd_idx,
    input  logic [FRAME_BITS-1:0]                        i_wr_frame,
    input  logic [TLBL_STAMP_BITS-1:0]                   i_wr_stamp,
    input  t_wave_ctl                                    i_ctl,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_fidx,
    input  logic [FRAME_BITS-1:0]                        i_fframe,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_free_idx,
    input  logic [TLBL_STAMP_BITS-1:0]                   i_min_stamp,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_min_idx,
    input  logic [PAGE_BITS-1:0]                         i_min_page,
    input  logic [$clog2(ENTRIES+1)-1:0]                 i_count,
    output t_wave_ctl                                    o_ctl,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_fidx,
    output logic [FRAME_BITS-1:0]                        o_fframe,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_free_idx,
    output logic [TLBL_STAMP_BITS-1:0]                   o_min_stamp,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_min_idx,
    output logic [PAGE_BITS-1:0]                         o_min_page,
    output logic [$clog2(ENTRIES+1)-1:0]                 o_count
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    // entry storage
    logic                       r_valid;
    logic [PAGE_BITS-1:0]       r_page;
    logic [FRAME_BITS-1:0]      r_frame;
    logic [TLBL_STAMP_BITS-1:0] r_stamp;

    // wave stage
    t_wave_ctl                  r_ctl, n_ctl;
    logic [IW-1:0]              r_fidx, n_fidx;
    logic [FRAME_BITS-1:0]      r_fframe, n_fframe;
    logic [IW-1:0]              r_free_idx, n_free_idx;
    logic [TLBL_STAMP_BITS-1:0] r_min_stamp, n_min_stamp;
    logic [IW-1:0]              r_min_idx, n_min_idx;
    logic [PAGE_BITS-1:0]       r_min_page, n_min_page;
    logic [CW-1:0]              r_count, n_count;

    logic sel;
    logic match;

    assign sel   = (i_upd_idx == MY_IDX);
    assign match = r_valid && (r_page == i_page);

    always_comb begin
        n_ctl       = i_ctl;
        n_fidx      = i_fidx;
        n_fframe    = i_fframe;
        n_free_idx  = i_free_idx;
        n_min_stamp = i_min_stamp;
        n_min_idx   = i_min_idx;
        n_min_page  = i_min_page;
        n_count     = i_count + CW'(r_valid);
        // lowest matching entry wins
        if (!i_ctl.found && match) begin
            n_ctl.found = 1'b1;
            n_fidx      = MY_IDX;
            n_fframe    = r_frame;
        end
        // lowest free slot wins
        if (!i_ctl.free_found && !r_valid) begin
            n_ctl.free_found = 1'b1;
            n_free_idx       = MY_IDX;
        end
        // strict compare keeps the lower index on a tie
        if (r_valid && (!i_ctl.min_set || (r_stamp < i_min_stamp))) begin
            n_ctl.min_set = 1'b1;
            n_min_stamp   = r_stamp;
            n_min_idx     = MY_IDX;
            n_min_page    = r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ctl   <= '0;
        end else begin
            r_ctl <= n_ctl;
            if (i_wr_en && sel) begin
                r_valid <= 1'b1;
            end else if (i_inv_en && sel) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && sel) begin
            r_page  <= i_page;
            r_frame <= i_wr_frame;
            r_stamp <= i_wr_stamp;
        end
        r_fidx      <= n_fidx;
        r_fframe    <= n_fframe;
        r_free_idx  <= n_free_idx;
        r_min_stamp <= n_min_stamp;
        r_min_idx   <= n_min_idx;
        r_min_page  <= n_min_page;
        r_count     <= n_count;
    end

    assign o_ctl       = r_ctl;
    assign o_fidx      = r_fidx;
    assign o_fframe    = r_fframe;
    assign o_free_idx  = r_free_idx;
    assign o_min_stamp = r_min_stamp;
    assign o_min_idx   = r_min_idx;
    assign o_min_page  = r_min_page;
    assign o_count     = r_count;

endmodule

FILE: hdl/tlb_lru_fully_associative.sv
// ----------------------------------------------------------------------------
// tlb_lru_fully_associative
// fully associative translation buffer with least-recently-stamped eviction
// ----------------------------------------------------------------------------
// The buffer is a row of ENTRIES cells, each holding one entry (valid, page,
// frame, last-use stamp). An accepted item launches a scan wave that moves one
// cell per clock down the row, picking up the lowest matching entry, the
// lowest free slot, the smallest stamp among valid entries and the running
// valid count. When the wave leaves the last cell the operation is resolved:
// an insert writes the free slot (or evicts the oldest stamp), a flush clears
// the matched entry, and the result is registered. The input is ready again
// as soon as the result is handed to the output register, so a new item can
// scan while a finished result waits. Lookups never touch stamps; inserts do
// not check for an existing copy of the page. Valid bits clear at reset, so
// the buffer is usable on the first item.
// ----------------------------------------------------------------------------
module tlb_lru_fully_associative
    import tlbl_pkg::*;
#(
    parameter int ENTRIES    = TLBL_ENTRIES,
    parameter int PAGE_BITS  = TLBL_PAGE_BITS,
    parameter int FRAME_BITS = TLBL_FRAME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // fields from bit 0: func[2], page_number[20], frame_number[20],
    // access_stamp[32], zero pad[6]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // fields from bit 0: hit[1], hit_index[5], frame_out[20], evicted_valid[1],
    // evicted_page[20], valid_count[6], zero pad[3]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

`include "tlb_lru_fully_associative_assert.svh"

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // control
    t_state r_state, n_state;
    logic   r_inject;
    logic   s_fire;
    logic   out_free;
    logic   end_act;

    // held request
    t_func                      r_func;
    logic [PAGE_BITS-1:0]       r_page;
    logic [FRAME_BITS-1:0]      r_frame;
    logic [TLBL_STAMP_BITS-1:0] r_stamp;

    // wave links, index i feeds cell i
    t_wave_ctl                  w_ctl       [ENTRIES+1];
    logic [IW-1:0]              w_fidx      [ENTRIES+1];
    logic [FRAME_BITS-1:0]      w_fframe    [ENTRIES+1];
    logic [IW-1:0]              w_free_idx  [ENTRIES+1];
    logic [TLBL_STAMP_BITS-1:0] w_min_stamp [ENTRIES+1];
    logic [IW-1:0]              w_min_idx   [ENTRIES+1];
    logic [PAGE_BITS-1:0]       w_min_page  [ENTRIES+1];
    logic [CW-1:0]              w_count     [ENTRIES+1];

    // write-back to the row
    logic          wr_en;
    logic          inv_en;
    logic [IW-1:0] upd_idx;

    // resolved result
    logic                  n_res_hit,   r_res_hit;
    logic [IW-1:0]         n_res_idx,   r_res_idx;
    logic [FRAME_BITS-1:0] n_res_frame, r_res_frame;
    logic                  n_res_ev,    r_res_ev;
    logic [PAGE_BITS-1:0]  n_res_page,  r_res_page;
    logic [CW-1:0]         n_res_count, r_res_count;

    // output register
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    assign s_tready = (r_state == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !r_out_valid || m_tready;
    assign end_act  = w_ctl[ENTRIES].active;

    // request capture
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_func  <= t_func'(s_tdata[1:0]);
            r_page  <= PAGE_BITS'(s_tdata[21:2]);
            r_frame <= FRAME_BITS'(s_tdata[41:22]);
            r_stamp <= s_tdata[73:42];
        end
    end

    // wave enters cell 0 in the cycle after accept, once the request is held
    always_comb begin
        w_ctl[0]        = '0;
        w_ctl[0].active = r_inject;
        w_fidx[0]       = '0;
        w_fframe[0]     = '0;
        w_free_idx[0]   = '0;
        w_min_stamp[0]  = '0;
        w_min_idx[0]    = '0;
        w_min_page[0]   = '0;
        w_count[0]      = '0;
    end

    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
        tlbl_cell #(
            .ENTRIES    (ENTRIES),
            .PAGE_BITS  (PAGE_BITS),
            .FRAME_BITS (FRAME_BITS),
            .IDX        (gi)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_page      (r_page),
            .i_wr_en     (wr_en),
            .i_inv_en    (inv_en),
            .i_upd_idx   (upd_idx),
            .i_wr_frame  (r_frame),
            .i_wr_stamp  (r_stamp),
            .i_ctl       (w_ctl[gi]),
            .i_fidx      (w_fidx[gi]),
            .i_fframe    (w_fframe[gi]),
            .i_free_idx  (w_free_idx[gi]),
            .i_min_stamp (w_min_stamp[gi]),
            .i_min_idx   (w_min_idx[gi]),
            .i_min_page  (w_min_page[gi]),
            .i_count     (w_count[gi]),
            .o_ctl       (w_ctl[gi+1]),
            .o_fidx      (w_fidx[gi+1]),
            .o_fframe    (w_fframe[gi+1]),
            .o_free_idx  (w_free_idx[gi+1]),
            .o_min_stamp (w_min_stamp[gi+1]),
            .o_min_idx   (w_min_idx[gi+1]),
            .o_min_page  (w_min_page[gi+1]),
            .o_count     (w_count[gi+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (end_act) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // resolve the operation when the wave leaves the row
    always_comb begin
        wr_en       = 1'b0;
        inv_en      = 1'b0;
        upd_idx     = '0;
        n_res_hit   = 1'b0;
        n_res_idx   = '0;
        n_res_frame = '0;
        n_res_ev    = 1'b0;
        n_res_page  = '0;
        n_res_count = w_count[ENTRIES];
        case (r_func)
            FUNC_LOOKUP: begin
                if (w_ctl[ENTRIES].found) begin
                    n_res_hit   = 1'b1;
                    n_res_idx   = w_fidx[ENTRIES];
                    n_res_frame = w_fframe[ENTRIES];
                end
            end
            FUNC_INSERT: begin
                wr_en = (r_state == S_SCAN) && end_act;
                if (w_ctl[ENTRIES].free_found) begin
                    upd_idx     = w_free_idx[ENTRIES];
                    n_res_count = w_count[ENTRIES] + CW'(1);
                end else begin
                    // every entry valid: evict the oldest stamp
                    upd_idx    = w_min_idx[ENTRIES];
                    n_res_ev   = 1'b1;
                    n_res_page = w_min_page[ENTRIES];
                end
                n_res_idx = upd_idx;
            end
            FUNC_FLUSH: begin
                if (w_ctl[ENTRIES].found) begin
                    inv_en      = (r_state == S_SCAN) && end_act;
                    upd_idx     = w_fidx[ENTRIES];
                    n_res_hit   = 1'b1;
                    n_res_idx   = w_fidx[ENTRIES];
                    n_res_count = w_count[ENTRIES] - CW'(1);
                end
            end
            default: begin
                // unused code leaves the buffer untouched
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inject    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inject <= s_fire;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result hold and output payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && end_act) begin
            r_res_hit   <= n_res_hit;
            r_res_idx   <= n_res_idx;
            r_res_frame <= n_res_frame;
            r_res_ev    <= n_res_ev;
            r_res_page  <= n_res_page;
            r_res_count <= n_res_count;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_data <= {3'b000,
                           F_CNT_W'(r_res_count),
                           F_PAGE_W'(r_res_page),
                           r_res_ev,
                           F_FRAME_W'(r_res_frame),
                           F_IDX_W'(r_res_idx),
                           r_res_hit};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // no wave reaches the end of the row unless a scan is running
    `TLBL_ASSERT_IMPLY(a_wave_in_scan, i_clk, i_rst_n, end_act, r_state == S_SCAN)
    // an accepted item always starts a scan
    `TLBL_ASSERT_NEXT(a_accept_scans, i_clk, i_rst_n, s_fire, (r_state == S_SCAN) && r_inject)
    // an insert never reports a hit (a flush never evicts, but that is not checked here)
    `TLBL_ASSERT_IMPLY(a_insert_no_hit, i_clk, i_rst_n,
        (r_state == S_DONE) && (r_func == FUNC_INSERT), !r_res_hit)
    `TLBL_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n,
        r_state == S_DONE, r_res_count <= CW'(ENTRIES))

endmodule
